>>> sv/dip_pkg.sv
package dip_pkg;

  localparam int unsigned ChW  = 8;
  localparam int unsigned MagW = 32;
  // Digit accumulation needs mag*10+9 with mag <= 2^31.
  localparam int unsigned AccW = MagW + 4;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChPlus  = 8'h2b;
  localparam logic [ChW-1:0] ChMinus = 8'h2d;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0d;

  // 2^31: largest magnitude, legal only when negative.
  localparam logic [MagW-1:0] MagLimit = 32'h8000_0000;

  typedef enum logic [5:0] {
    PhLead   = 6'b000001,
    PhSigned = 6'b000010,
    PhZero   = 6'b000100,
    PhDigits = 6'b001000,
    PhTrail  = 6'b010000,
    PhBad    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic            ovf;
    logic [MagW-1:0] mag;
  } acc_t;

  function automatic logic is_ws(input logic [ChW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

>>> sv/dip_if.sv
interface dip_in_if;
  logic                      valid;
  logic                      ready;
  logic [dip_pkg::ChW-1:0]   ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface dip_out_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_res;
  logic signed [dip_pkg::MagW-1:0] value;

  modport source (output valid, output valid_res, output value, input ready);
  modport sink   (input valid, input valid_res, input value, output ready);
endinterface

>>> sv/dip_accum.sv
module dip_accum (
  input  dip_pkg::acc_t            acc_i,
  input  logic [dip_pkg::ChW-1:0]  ch_i,
  output dip_pkg::acc_t            acc_o
);
  import dip_pkg::*;

  logic [AccW-1:0] mag_ext;
  logic [AccW-1:0] digit;
  logic [AccW-1:0] sum;

  assign mag_ext = {{(AccW-MagW){1'b0}}, acc_i.mag};
  assign digit   = {{(AccW-ChW){1'b0}}, ch_i - ChZero};
  // x*10 = x*8 + x*2
  assign sum     = (mag_ext << 3) + (mag_ext << 1) + digit;

  always_comb begin
    acc_o = acc_i;
    if (!acc_i.ovf) begin
      if (sum > {{(AccW-MagW){1'b0}}, MagLimit}) begin
        acc_o.ovf = 1'b1;
      end else begin
        acc_o.mag = sum[MagW-1:0];
      end
    end
  end

endmodule

>>> sv/decimal_int32_text_parser.sv
// Strict decimal text to int32 parser.
// in_i carries one text byte per request (ch); byte 0 terminates the text.
// Leading/trailing whitespace, one optional sign, and at least one digit are
// accepted; a leading zero must stand alone. Each terminator produces one
// request on out_o: valid_res and the signed value (0 when not valid).
// Other bytes produce nothing. After the terminator the parser rearms.
// Throughput: one byte per cycle while no terminator waits on a stalled out_o.
// Each byte is registered, then one multiply-by-ten-and-add plus phase update
// runs before the state and result registers, so a terminator passes the input
// register and then the result registers before its result shows on out_o.
// When out_o stalls, non-terminator bytes keep flowing; a terminator waits
// in the input register until the pending result is taken, and in_i.ready
// drops only then.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the leading-whitespace phase.
module decimal_int32_text_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  dip_in_if.sink    in_i,
  dip_out_if.source out_o
);
  import dip_pkg::*;

  logic           s1_vld_q;
  logic [ChW-1:0] ch_q;
  logic           s1_go;
  logic           term;

  phase_e phase_q, phase_d;
  logic   neg_q, neg_d;
  acc_t   acc_q, acc_d, acc_add;

  logic            out_vld_q, out_vld_d;
  logic            res_ok_q, res_ok_d;
  logic [MagW-1:0] res_val_q, res_val_d;
  logic            ok;

  assign term  = (ch_q == ChNul);
  assign s1_go = s1_vld_q && (!term || !out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_go;

  dip_accum u_accum (
    .acc_i (acc_q),
    .ch_i  (ch_q),
    .acc_o (acc_add)
  );

  assign ok = ((phase_q == PhZero) || (phase_q == PhDigits) || (phase_q == PhTrail))
              && !acc_q.ovf && (neg_q || (acc_q.mag < MagLimit));

  always_comb begin
    phase_d   = phase_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    out_vld_d = out_vld_q && !out_o.ready;
    res_ok_d  = res_ok_q;
    res_val_d = res_val_q;
    if (s1_go) begin
      if (term) begin
        out_vld_d = 1'b1;
        res_ok_d  = ok;
        res_val_d = ok ? (neg_q ? (MagW'(0) - acc_q.mag) : acc_q.mag) : '0;
        phase_d   = PhLead;
        neg_d     = 1'b0;
        acc_d     = '0;
      end else begin
        case (phase_q)
          PhLead: begin
            if (is_ws(ch_q)) begin
              phase_d = PhLead;
            end else if ((ch_q == ChPlus) || (ch_q == ChMinus)) begin
              neg_d   = (ch_q == ChMinus);
              phase_d = PhSigned;
            end else if (ch_q == ChZero) begin
              phase_d = PhZero;
            end else if (is_digit(ch_q)) begin
              acc_d   = acc_add;
              phase_d = PhDigits;
            end else begin
              phase_d = PhBad;
            end
          end
          PhSigned: begin
            if (ch_q == ChZero) begin
              phase_d = PhZero;
            end else if (is_digit(ch_q)) begin
              acc_d   = acc_add;
              phase_d = PhDigits;
            end else begin
              phase_d = PhBad;
            end
          end
          PhZero: begin
            phase_d = is_ws(ch_q) ? PhTrail : PhBad;
          end
          PhDigits: begin
            if (is_digit(ch_q)) begin
              acc_d = acc_add;
            end else begin
              phase_d = is_ws(ch_q) ? PhTrail : PhBad;
            end
          end
          PhTrail: begin
            if (!is_ws(ch_q)) begin
              phase_d = PhBad;
            end
          end
          default: begin
            phase_d = PhBad;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      phase_q   <= PhLead;
      neg_q     <= 1'b0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end
      phase_q   <= phase_d;
      neg_q     <= neg_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ch_q <= in_i.ch;
    end
    res_ok_q  <= res_ok_d;
    res_val_q <= res_val_d;
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.valid_res = res_ok_q;
  assign out_o.value     = signed'(res_val_q);

endmodule
